[rtl/core/dprq_pkg.sv]
// Shared types and constants for the dual priority request queue.
// No dependencies; imported by the core top level.
package dprq_pkg;

  // Fixed field widths of the stream payloads
  localparam int PRI_W       = 2;
  localparam int FIELD_ID_W  = 16;
  localparam int FIELD_CNT_W = 5;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  localparam logic [PRI_W-1:0] PRI_NONE = 2'd0;
  localparam logic [PRI_W-1:0] PRI_TOP  = 2'd1;

endpackage

[rtl/core/dual_priority_request_queue_core.sv]
// Dual priority request queue: two sorted queues (read, write) with a shared id counter.
// Depends on dprq_pkg and dprq_ram.
//
//  channel  | direction | tdata                                   | tuser
//  s_axis   | in        | priority_req, remove_id                 | operation, queue_sel
//  m_axis   | out       | assigned_id, head_valid, head_id,       | status
//           |           | head_priority, queue_count              |
//
// One transaction at a time. An insert or a remove walks over the selected queue in the
// queue RAM, one entry per cycle through its single read and write port.
// rst is synchronous: both queues empty, id counter at zero.
// A finished result waits in the output register; the next input transaction is
// taken meanwhile, and a further result stalls until the first has been taken.
module dual_priority_request_queue_core
  import dprq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [1:0] priority_req, [17:2] remove_id, [23:18] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] operation, [1] queue_sel
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] assigned_id, [16] head_valid, [32:17] head_id, [34:33] head_priority,
  // [39:35] queue_count
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W     = ID_WIDTH + PRI_W;
  localparam int RAM_AW    = IDX_W + 1;
  localparam int RAM_DEPTH = 1 << RAM_AW;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISCAN,
    S_RSCAN,
    S_WNEW,
    S_HRD,
    S_HRES
  } state_t;

  state_t              state;
  logic                op_rm;
  logic                sel;
  logic [PRI_W-1:0]    pri;
  logic [ID_WIDTH-1:0] rid;
  logic [ID_WIDTH-1:0] next_id;
  logic [ID_WIDTH-1:0] asg;
  status_t             st;
  logic [CNT_W-1:0]    cnt_q [2];
  logic [IDX_W-1:0]    ptr;
  logic [IDX_W-1:0]    didx;
  logic [IDX_W-1:0]    wpos;
  logic                more;
  logic                vld;
  logic                found;

  logic                ram_we;
  logic [RAM_AW-1:0]   ram_waddr;
  logic [ENT_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [RAM_AW-1:0]   ram_raddr;
  logic [ENT_W-1:0]    ram_rdata;

  logic [ID_WIDTH-1:0] ent_id;
  logic [PRI_W-1:0]    ent_pri;
  logic                hit;
  logic [CNT_W-1:0]    cnt_sel;
  logic [CNT_W-1:0]    cnt_in;
  logic [PRI_W-1:0]    pri_in;
  logic [31:0]         rid32;
  logic [31:0]         ent_id32;
  logic [31:0]         asg32;
  logic [31:0]         cnt32;
  logic                head_valid;

  assign ent_id   = ram_rdata[ENT_W-1:PRI_W];
  assign ent_pri  = ram_rdata[PRI_W-1:0];
  assign hit      = found || (ent_id == rid);
  assign cnt_sel  = cnt_q[sel];
  assign cnt_in   = cnt_q[s_axis_tuser[1]];
  assign pri_in   = (s_axis_tdata[1:0] == PRI_NONE) ? PRI_TOP : s_axis_tdata[1:0];
  assign rid32    = 32'(s_axis_tdata[17:2]);
  assign ent_id32 = 32'(ent_id);
  assign asg32    = 32'(asg);
  assign cnt32    = 32'(cnt_sel);
  assign head_valid = (cnt_sel != '0);

  assign s_axis_tready = (state == S_IDLE);

  dprq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // RAM port control; reads run one entry ahead of the evaluated one
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {sel, ptr};
    ram_we    = 1'b0;
    ram_waddr = {sel, wpos};
    ram_wdata = {next_id, pri};
    unique case (state)
      S_ISCAN: begin
        ram_re = more;
        // entry worse than the new one moves one place towards the tail
        if (vld && (ent_pri > pri)) begin
          ram_we    = 1'b1;
          ram_waddr = {sel, didx + IDX_ONE};
          ram_wdata = ram_rdata;
        end
      end
      S_RSCAN: begin
        ram_re = more;
        // entries behind the removed one close the gap
        if (vld && found) begin
          ram_we    = 1'b1;
          ram_waddr = {sel, didx - IDX_ONE};
          ram_wdata = ram_rdata;
        end
      end
      S_WNEW: begin
        ram_we = 1'b1;
      end
      S_HRD: begin
        ram_re    = 1'b1;
        ram_raddr = {sel, {IDX_W{1'b0}}};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt_q[0]      <= '0;
      cnt_q[1]      <= '0;
      next_id       <= '0;
      m_axis_tvalid <= 1'b0;
      vld           <= 1'b0;
      more          <= 1'b0;
      found         <= 1'b0;
    end else begin
      // in S_HRES the output register is handled below
      if (m_axis_tready && (state != S_HRES)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          vld   <= 1'b0;
          found <= 1'b0;
          if (s_axis_tvalid) begin
            op_rm <= s_axis_tuser[0];
            sel   <= s_axis_tuser[1];
            pri   <= pri_in;
            rid   <= rid32[ID_WIDTH-1:0];
            asg   <= '0;
            if (s_axis_tuser[0] == OP_INSERT) begin
              if (cnt_in == CNT_FULL) begin
                st    <= ST_FULL;
                state <= S_HRD;
              end else if (cnt_in == '0) begin
                st    <= ST_OK;
                wpos  <= '0;
                state <= S_WNEW;
              end else begin
                st    <= ST_OK;
                ptr   <= IDX_W'(cnt_in - CNT_ONE);
                more  <= 1'b1;
                state <= S_ISCAN;
              end
            end else begin
              if (cnt_in == '0) begin
                st    <= ST_NOT_FOUND;
                state <= S_HRD;
              end else begin
                st    <= ST_OK;
                ptr   <= '0;
                more  <= 1'b1;
                state <= S_RSCAN;
              end
            end
          end
        end
        S_ISCAN: begin
          // walk from the tail towards the head
          if (more) begin
            vld  <= 1'b1;
            didx <= ptr;
            ptr  <= ptr - IDX_ONE;
            more <= (ptr != '0);
          end else begin
            vld <= 1'b0;
          end
          if (vld) begin
            if (ent_pri > pri) begin
              if (didx == '0) begin
                wpos  <= '0;
                state <= S_WNEW;
              end
            end else begin
              wpos  <= didx + IDX_ONE;
              state <= S_WNEW;
            end
          end
        end
        S_RSCAN: begin
          if (more) begin
            vld  <= 1'b1;
            didx <= ptr;
            ptr  <= ptr + IDX_ONE;
            more <= ((CNT_W'(ptr) + CNT_ONE) < cnt_sel);
          end else begin
            vld <= 1'b0;
          end
          if (vld) begin
            found <= hit;
            if (didx == IDX_W'(cnt_sel - CNT_ONE)) begin
              if (hit) begin
                cnt_q[sel] <= cnt_sel - CNT_ONE;
              end else begin
                st <= ST_NOT_FOUND;
              end
              state <= S_HRD;
            end
          end
        end
        S_WNEW: begin
          cnt_q[sel] <= cnt_sel + CNT_ONE;
          asg        <= next_id;
          next_id    <= next_id + ID_WIDTH'(1);
          state      <= S_HRD;
        end
        S_HRD: begin
          state <= S_HRES;
        end
        S_HRES: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= st;
            m_axis_tdata  <= {cnt32[FIELD_CNT_W-1:0],
                              head_valid ? ent_pri : PRI_NONE,
                              head_valid ? ent_id32[FIELD_ID_W-1:0] : {FIELD_ID_W{1'b0}},
                              head_valid,
                              asg32[FIELD_ID_W-1:0]};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // op_rm is kept for the checks below
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt_q[0] <= CNT_FULL) && (cnt_q[1] <= CNT_FULL))
    else $error("queue count beyond depth");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("queue RAM written while idle");

  a_id_advance: assert property (@(posedge clk) disable iff (rst)
    (next_id != $past(next_id)) |-> ($past(state) == S_WNEW))
    else $error("id counter moved outside an insert");

  a_remove_no_id: assert property (@(posedge clk) disable iff (rst)
    ((state == S_HRES) && (op_rm == OP_REMOVE)) |-> (asg == '0))
    else $error("remove carries an assigned id");

  a_full_no_id: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |-> (m_axis_tdata[FIELD_ID_W-1:0] == '0))
    else $error("full insert reports an id");

endmodule

[rtl/core/dprq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds both request queues in the core.
module dprq_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sim/tb.sv]
// Self-checking bench for dual_priority_request_queue_core: directed table and random
// traffic with bursts and stalls. Depends on dprq_pkg.
`timescale 1ns / 100ps

module tb;
  import dprq_pkg::*;

  localparam int QDEPTH = 16;
  localparam logic SEL_READ  = 1'b0;
  localparam logic SEL_WRITE = 1'b1;

  typedef struct packed {
    status_t                status;
    logic [FIELD_ID_W-1:0]  assigned_id;
    logic                   head_valid;
    logic [FIELD_ID_W-1:0]  head_id;
    logic [PRI_W-1:0]       head_pri;
    logic [FIELD_CNT_W-1:0] count;
  } outcome_t;

  typedef struct packed {
    op_t                   op;
    logic                  sel;
    logic [PRI_W-1:0]      pri;
    logic [FIELD_ID_W-1:0] rid;
    logic                  typed;
    outcome_t              want;
  } dir_row_t;

  typedef enum int {PH_MIX, PH_FILL, PH_DRAIN} phase_kind_t;

  localparam outcome_t ANY = '{ST_OK, 16'd0, 1'b0, 16'd0, 2'd0, 5'd0};

  // typed rows carry their outcome; the others are left to the shadow queues
  localparam dir_row_t DIRECTED [18] = '{
    '{OP_REMOVE, SEL_READ,  2'd0, 16'h0000, 1'b1, '{ST_NOT_FOUND, 16'd0, 1'b0, 16'd0, 2'd0, 5'd0}},
    '{OP_REMOVE, SEL_WRITE, 2'd3, 16'hFFFF, 1'b1, '{ST_NOT_FOUND, 16'd0, 1'b0, 16'd0, 2'd0, 5'd0}},
    '{OP_INSERT, SEL_READ,  2'd0, 16'h0000, 1'b1, '{ST_OK, 16'd0, 1'b1, 16'd0, 2'd1, 5'd1}},
    '{OP_INSERT, SEL_READ,  2'd3, 16'h0000, 1'b1, '{ST_OK, 16'd1, 1'b1, 16'd0, 2'd1, 5'd2}},
    '{OP_INSERT, SEL_WRITE, 2'd3, 16'h0000, 1'b1, '{ST_OK, 16'd2, 1'b1, 16'd2, 2'd3, 5'd1}},
    '{OP_INSERT, SEL_WRITE, 2'd2, 16'h0000, 1'b1, '{ST_OK, 16'd3, 1'b1, 16'd3, 2'd2, 5'd2}},
    '{OP_INSERT, SEL_WRITE, 2'd1, 16'h0000, 1'b1, '{ST_OK, 16'd4, 1'b1, 16'd4, 2'd1, 5'd3}},
    '{OP_INSERT, SEL_WRITE, 2'd1, 16'h0000, 1'b0, ANY},
    '{OP_INSERT, SEL_READ,  2'd2, 16'h0000, 1'b0, ANY},
    '{OP_REMOVE, SEL_WRITE, 2'd0, 16'h0004, 1'b0, ANY},
    '{OP_REMOVE, SEL_WRITE, 2'd0, 16'h0004, 1'b1, '{ST_NOT_FOUND, 16'd0, 1'b1, 16'd5, 2'd1, 5'd3}},
    '{OP_REMOVE, SEL_READ,  2'd0, 16'hFFFF, 1'b1, '{ST_NOT_FOUND, 16'd0, 1'b1, 16'd0, 2'd1, 5'd3}},
    '{OP_REMOVE, SEL_READ,  2'd0, 16'h0006, 1'b0, ANY},
    '{OP_REMOVE, SEL_READ,  2'd0, 16'h0000, 1'b0, ANY},
    '{OP_REMOVE, SEL_READ,  2'd0, 16'h0001, 1'b1, '{ST_OK, 16'd0, 1'b0, 16'd0, 2'd0, 5'd0}},
    '{OP_INSERT, SEL_WRITE, 2'd3, 16'hFFFF, 1'b0, ANY},
    '{OP_REMOVE, SEL_WRITE, 2'd0, 16'h0007, 1'b0, ANY},
    '{OP_REMOVE, SEL_WRITE, 2'd0, 16'h0005, 1'b0, ANY}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [1:0] priority_req, [17:2] remove_id
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // [0] operation, [1] queue_sel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [15:0] assigned_id, [16] head_valid, [32:17] head_id, [34:33] head_priority,
  // [39:35] queue_count
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;        // [1:0] status

  dual_priority_request_queue_core #(
    .QUEUE_DEPTH(QDEPTH),
    .ID_WIDTH   (FIELD_ID_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // shadow copy of both queues and the id counter
  logic [FIELD_ID_W-1:0] shadow_ids [2][QDEPTH];
  logic [PRI_W-1:0]      shadow_pri [2][QDEPTH];
  int                    shadow_cnt [2];
  logic [FIELD_ID_W-1:0] shadow_next_id;

  outcome_t awaited_outcomes [$];
  outcome_t got_o, want_o;
  int       mismatches = 0;
  int       outcomes_checked = 0;
  int       burst_left = 0;
  bit       hold_off = 1'b0;
  int       stall_mode = 0;
  int       stall_left = 0;
  bit       stall_toggle = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("dual_priority_request_queue_core verification failed");
    $finish;
  end

  task automatic apply_request(input op_t op, input logic sel, input logic [PRI_W-1:0] pri_in,
                               input logic [FIELD_ID_W-1:0] rid, output outcome_t o);
    int n;
    int pos;
    logic [PRI_W-1:0] p;
    n = shadow_cnt[sel];
    p = (pri_in == PRI_NONE) ? PRI_TOP : pri_in;
    o = ANY;
    if (op == OP_INSERT) begin
      if (n >= QDEPTH) begin
        o.status = ST_FULL;
      end else begin
        pos = 0;
        // stable: goes behind every entry of equal or better priority
        while (pos < n && shadow_pri[sel][pos] <= p) pos++;
        for (int k = n; k > pos; k--) begin
          shadow_ids[sel][k] = shadow_ids[sel][k-1];
          shadow_pri[sel][k] = shadow_pri[sel][k-1];
        end
        shadow_ids[sel][pos] = shadow_next_id;
        shadow_pri[sel][pos] = p;
        o.assigned_id = shadow_next_id;
        shadow_next_id = shadow_next_id + FIELD_ID_W'(1);
        shadow_cnt[sel] = n + 1;
        o.status = ST_OK;
      end
    end else begin
      pos = 0;
      while (pos < n && shadow_ids[sel][pos] != rid) pos++;
      if (pos >= n) begin
        o.status = ST_NOT_FOUND;
      end else begin
        for (int k = pos + 1; k < n; k++) begin
          shadow_ids[sel][k-1] = shadow_ids[sel][k];
          shadow_pri[sel][k-1] = shadow_pri[sel][k];
        end
        shadow_cnt[sel] = n - 1;
        o.status = ST_OK;
      end
    end
    n = shadow_cnt[sel];
    o.head_valid = (n > 0);
    o.head_id    = (n > 0) ? shadow_ids[sel][0] : '0;
    o.head_pri   = (n > 0) ? shadow_pri[sel][0] : '0;
    o.count      = n[FIELD_CNT_W-1:0];
  endtask

  // called at a falling edge; returns at a falling edge after the transaction, past any idle gap
  task automatic send_request(input op_t op, input logic sel, input logic [PRI_W-1:0] pri,
                              input logic [FIELD_ID_W-1:0] rid, input logic typed,
                              input outcome_t want);
    outcome_t o;
    int gap;
    s_axis_tuser  <= {sel, op};
    s_axis_tdata  <= {{(IN_TDATA_W-PRI_W-FIELD_ID_W){1'b0}}, rid, pri};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    apply_request(op, sel, pri, rid, o);
    awaited_outcomes.push_back(typed ? want : o);
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 25) : $urandom_range(0, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [FIELD_ID_W-1:0] pick_queued_id(input logic sel);
    if (shadow_cnt[sel] == 0) return FIELD_ID_W'($urandom_range(0, 65535));
    return shadow_ids[sel][$urandom_range(0, shadow_cnt[sel] - 1)];
  endfunction

  task automatic run_random(input int n_items);
    phase_kind_t kind;
    int left;
    int roll;
    int hit;
    logic tgt;
    logic sel;
    op_t op;
    logic [FIELD_ID_W-1:0] rid;
    kind = PH_MIX;
    left = 0;
    tgt  = SEL_READ;
    for (int i = 0; i < n_items; i++) begin
      if (left == 0) begin
        kind = phase_kind_t'($urandom_range(0, 2));
        left = $urandom_range(20, 60);
        tgt  = 1'($urandom_range(0, 1));
      end
      left--;
      roll = $urandom_range(0, 99);
      case (kind)
        PH_FILL: begin
          sel = (roll < 90) ? tgt : ~tgt;
          op  = (roll < 90) ? OP_INSERT : OP_REMOVE;
        end
        PH_DRAIN: begin
          sel = 1'($urandom_range(0, 1));
          op  = (roll < 85) ? OP_REMOVE : OP_INSERT;
        end
        default: begin
          sel = 1'($urandom_range(0, 1));
          op  = op_t'($urandom_range(0, 1));
        end
      endcase
      hit = (kind == PH_MIX) ? 6 : 9;
      if (op == OP_REMOVE && $urandom_range(0, 9) < hit)
        rid = pick_queued_id(sel);
      else if ($urandom_range(0, 15) == 0)
        rid = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else
        rid = FIELD_ID_W'($urandom_range(0, 65535));
      send_request(op, sel, PRI_W'($urandom_range(0, 3)), rid, 1'b0, ANY);
    end
  endtask

  task automatic check_field(input string name, input logic [FIELD_ID_W-1:0] want,
                             input logic [FIELD_ID_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_o.status      = status_t'(m_axis_tuser[1:0]);
      got_o.assigned_id = m_axis_tdata[15:0];
      got_o.head_valid  = m_axis_tdata[16];
      got_o.head_id     = m_axis_tdata[32:17];
      got_o.head_pri    = m_axis_tdata[34:33];
      got_o.count       = m_axis_tdata[39:35];
      if (awaited_outcomes.size() == 0) begin
        $error("result transaction with nothing outstanding");
        mismatches++;
      end else begin
        want_o = awaited_outcomes.pop_front();
        check_field("status", FIELD_ID_W'(want_o.status), FIELD_ID_W'(got_o.status));
        check_field("assigned_id", want_o.assigned_id, got_o.assigned_id);
        check_field("head_valid", FIELD_ID_W'(want_o.head_valid),
                    FIELD_ID_W'(got_o.head_valid));
        check_field("head_id", want_o.head_id, got_o.head_id);
        check_field("head_priority", FIELD_ID_W'(want_o.head_pri),
                    FIELD_ID_W'(got_o.head_pri));
        check_field("queue_count", FIELD_ID_W'(want_o.count), FIELD_ID_W'(got_o.count));
      end
      outcomes_checked++;
    end
  end

  // receiver stall pattern, drawn anew whenever its random countdown runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 80);
    end else begin
      stall_left--;
    end
    stall_toggle = ~stall_toggle;
    if (hold_off)
      m_axis_tready <= 1'b0;
    else
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
        2:       m_axis_tready <= ($urandom_range(0, 9) < 3);
        default: m_axis_tready <= stall_toggle;
      endcase
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (outcomes_checked >= 300);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    shadow_cnt[0]  = 0;
    shadow_cnt[1]  = 0;
    shadow_next_id = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECTED); i++)
      send_request(DIRECTED[i].op, DIRECTED[i].sel, DIRECTED[i].pri, DIRECTED[i].rid,
                   DIRECTED[i].typed, DIRECTED[i].want);

    run_random(1730);

    run_random(150);
    s_axis_tvalid <= 1'b0;

    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("dual_priority_request_queue_core verification clean");
    else
      $display("dual_priority_request_queue_core verification failed");
    $finish;
  end

endmodule
